// ===== hw/rtl/lzmc_pkg.sv =====
// Shared types, constants and functions of the Lzip member checker.
// No dependencies; used by the interfaces and all lzmc modules.
`timescale 1ns / 1ps
`default_nettype none

package lzmc_pkg;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 4;
    localparam int DICT_W   = 30;
    localparam int LEN_W    = 64;
    localparam int CRC_W    = 32;
    localparam int IDX_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_HEADER  = 2'd0,
        CMD_TRAILER = 2'd1,
        CMD_OUTPUT  = 2'd2,
        CMD_FINISH  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 4'd0,
        ST_MAGIC       = 4'd1,
        ST_VERSION     = 4'd2,
        ST_DICT        = 4'd3,
        ST_MEMBER_SIZE = 4'd4,
        ST_DATA_SIZE   = 4'd5,
        ST_OVERFLOW    = 4'd6,
        ST_LENGTH      = 4'd7,
        ST_CRC         = 4'd8,
        ST_SEQUENCE    = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_TRAILER = 3'b010,
        PH_DATA    = 3'b100
    } phase_t;

    // header / trailer byte positions
    localparam logic [IDX_W-1:0] IDX_VERSION   = 5'd4;
    localparam logic [IDX_W-1:0] HEADER_LAST   = 5'd5;
    localparam logic [IDX_W-1:0] CRC_FIELD_END = 5'd4;
    localparam logic [IDX_W-1:0] DSIZE_END     = 5'd12;
    localparam logic [IDX_W-1:0] TRAILER_LAST  = 5'd19;

    localparam logic [BYTE_W-1:0] LZIP_VERSION = 8'h01;
    localparam logic [LEN_W-1:0]  MIN_MEMBER   = 64'd36;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [4:0] DICT_EXP_MIN = 5'd12;
    localparam logic [4:0] DICT_EXP_MAX = 5'd29;
    localparam logic [30:0] DICT_MIN    = 31'd4096;
    localparam logic [30:0] DICT_MAX    = 31'd536870912;

    typedef struct packed {
        logic init;
        logic advance;
    } crc_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [DICT_W-1:0] size;
    } dict_t;

    function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] pos);
        logic [BYTE_W-1:0] m;
        unique case (pos)
            2'd0: m = 8'h4C;
            2'd1: m = 8'h5A;
            2'd2: m = 8'h49;
            2'd3: m = 8'h50;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // reflected CRC-32, one byte (eight bit steps)
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // size = 2^e - frac * 2^e / 16
    function automatic dict_t dict_decode(input logic [BYTE_W-1:0] code);
        dict_t       d;
        logic [4:0]  e;
        logic [2:0]  frac;
        logic [30:0] base;
        logic [30:0] val;
        e    = code[4:0];
        frac = code[7:5];
        base = 31'd1 << e;
        val  = base - 31'((base >> 4) * {28'd0, frac});
        d.valid = (e >= DICT_EXP_MIN) && (e <= DICT_EXP_MAX) &&
                  (val >= DICT_MIN) && (val <= DICT_MAX);
        d.size  = val[DICT_W-1:0];
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lzmc_req_if.sv =====
// Request channel of the Lzip member checker: command and data byte.
// Depends on lzmc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lzmc_req_if;
    logic                         valid;
    logic                         ready;
    logic [lzmc_pkg::CMD_W-1:0]   command;
    logic [lzmc_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lzmc_rsp_if.sv =====
// Result channel of the Lzip member checker: status, dictionary size, member ok.
// Depends on lzmc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lzmc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [lzmc_pkg::STATUS_W-1:0]  status;
    logic [lzmc_pkg::DICT_W-1:0]    dict_size;
    logic                           member_ok;

    modport source (output valid, output status, output dict_size,
                    output member_ok, input ready);
    modport sink   (input valid, input status, input dict_size,
                    input member_ok, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lzmc_crc32.sv =====
// Running CRC-32 register of the decompressed data, one byte per cycle while advance is set.
// Depends on lzmc_pkg (crc32_byte, crc_ctl_t).
`timescale 1ns / 1ps
`default_nettype none

module lzmc_crc32 (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lzmc_pkg::crc_ctl_t           ctl,
    input  wire logic [lzmc_pkg::BYTE_W-1:0]  data_byte,
    output logic      [lzmc_pkg::CRC_W-1:0]   crc
);
    import lzmc_pkg::*;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;

    always_comb
    begin
        priority if (ctl.init)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctl.advance)
        begin
            crc_next = crc32_byte(crc_reg, data_byte);
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lzmc_member_checker_top.sv =====
// Top level of the Lzip member checker: sequencing, checks and result register.
// Depends on lzmc_pkg, lzmc_req_if, lzmc_rsp_if and lzmc_crc32.
`timescale 1ns / 1ps
`default_nettype none

// Checks one Lzip member presented as a stream of requests: six header bytes,
// twenty trailer bytes (stored CRC, data size, member size, little-endian),
// then the decompressed output bytes, closed by a finish request. Every
// request yields exactly one result, registered in the cycle after it is accepted, and a
// new request is accepted every cycle as long as the result register is
// empty or being drained in the same cycle; the rate is one request per
// cycle, set by the combinational 64-bit count compare and increment and the
// byte-wide CRC-32 update. status holds the first error seen (sticky until
// finish), dict_size the decoded size once a clean header is complete,
// and member_ok is high only on the finish result of a clean member. Finish
// returns all member state to its reset values, ready for the next member.
module lzip_member_checker_top (
    input wire logic clk,
    input wire logic rst_n,
    lzmc_req_if.sink   req,
    lzmc_rsp_if.source rsp
);
    import lzmc_pkg::*;

    // member state
    phase_t             phase_reg,        phase_next;
    logic [IDX_W-1:0]   byte_index_reg,   byte_index_next;
    logic [DICT_W-1:0]  dict_size_reg,    dict_size_next;
    logic [CRC_W-1:0]   stored_crc_reg,   stored_crc_next;
    logic [LEN_W-1:0]   expected_len_reg, expected_len_next;
    logic [LEN_W-1:0]   member_len_reg,   member_len_next;
    logic [LEN_W-1:0]   written_cnt_reg,  written_cnt_next;
    status_t            error_reg,        error_next;

    // result register
    logic               rsp_valid_reg;
    status_t            status_reg,       status_next;
    logic [DICT_W-1:0]  rsp_dict_reg,     rsp_dict_next;
    logic               member_ok_reg,    member_ok_next;

    logic               req_fire;
    cmd_t               cmd;
    logic [BYTE_W-1:0]  data_b;
    status_t            err_new;
    dict_t              dict;
    crc_ctl_t           crc_ctl;
    logic [CRC_W-1:0]   running_crc;
    logic               finish;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign cmd       = cmd_t'(req.command);
    assign data_b    = req.data_byte;
    assign dict      = dict_decode(data_b);

    lzmc_crc32 u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (crc_ctl),
        .data_byte (data_b),
        .crc       (running_crc)
    );

    always_comb
    begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        dict_size_next    = dict_size_reg;
        stored_crc_next   = stored_crc_reg;
        expected_len_next = expected_len_reg;
        member_len_next   = member_len_reg;
        written_cnt_next  = written_cnt_reg;
        err_new           = ST_OK;
        crc_ctl           = '0;
        finish            = 1'b0;

        if (req_fire)
        begin
            unique case (cmd)
                CMD_HEADER:
                begin
                    if (phase_reg == PH_HEADER)
                    begin
                        if (byte_index_reg < IDX_VERSION)
                        begin
                            if (data_b != magic_byte(byte_index_reg[1:0]))
                                err_new = ST_MAGIC;
                        end
                        else if (byte_index_reg == IDX_VERSION)
                        begin
                            if (data_b != LZIP_VERSION)
                                err_new = ST_VERSION;
                        end
                        else if (dict.valid)
                        begin
                            // only a clean header publishes its size
                            if (error_reg == ST_OK)
                                dict_size_next = dict.size;
                        end
                        else
                        begin
                            err_new = ST_DICT;
                        end

                        if (byte_index_reg >= HEADER_LAST)
                        begin
                            phase_next      = PH_TRAILER;
                            byte_index_next = '0;
                        end
                        else
                        begin
                            byte_index_next = byte_index_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        err_new = ST_SEQUENCE;
                    end
                end

                CMD_TRAILER:
                begin
                    if (phase_reg == PH_TRAILER)
                    begin
                        if (byte_index_reg < CRC_FIELD_END)
                        begin
                            stored_crc_next[{byte_index_reg[1:0], 3'b000} +: 8] = data_b;
                        end
                        else if (byte_index_reg < DSIZE_END)
                        begin
                            expected_len_next[{3'(byte_index_reg - CRC_FIELD_END), 3'b000} +: 8]
                                = data_b;
                        end
                        else
                        begin
                            member_len_next[{3'(byte_index_reg - DSIZE_END), 3'b000} +: 8]
                                = data_b;
                        end

                        if (byte_index_reg >= TRAILER_LAST)
                        begin
                            if (member_len_next < MIN_MEMBER || member_len_next[LEN_W-1])
                                err_new = ST_MEMBER_SIZE;
                            else if (expected_len_next[LEN_W-1])
                                err_new = ST_DATA_SIZE;
                            phase_next      = PH_DATA;
                            byte_index_next = '0;
                        end
                        else
                        begin
                            byte_index_next = byte_index_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        err_new = ST_SEQUENCE;
                    end
                end

                CMD_OUTPUT:
                begin
                    if (phase_reg == PH_DATA)
                    begin
                        // bytes past the expected size are dropped
                        if (written_cnt_reg >= expected_len_reg)
                        begin
                            err_new = ST_OVERFLOW;
                        end
                        else
                        begin
                            crc_ctl.advance  = 1'b1;
                            written_cnt_next = written_cnt_reg + 64'd1;
                        end
                    end
                    else
                    begin
                        err_new = ST_SEQUENCE;
                    end
                end

                CMD_FINISH:
                begin
                    finish = 1'b1;
                    if (phase_reg != PH_DATA)
                        err_new = ST_SEQUENCE;
                    else if (written_cnt_reg != expected_len_reg)
                        err_new = ST_LENGTH;
                    else if ((running_crc ^ CRC_INIT) != stored_crc_reg)
                        err_new = ST_CRC;
                end

                default:
                begin
                    err_new = ST_OK;
                end
            endcase
        end

        // first error sticks
        status_next    = (error_reg == ST_OK) ? err_new : error_reg;
        member_ok_next = finish && (status_next == ST_OK);
        error_next     = status_next;
        // result shows the size as updated by this request, before any rewind
        rsp_dict_next  = dict_size_next;

        if (finish)
        begin
            phase_next        = PH_HEADER;
            byte_index_next   = '0;
            dict_size_next    = '0;
            stored_crc_next   = '0;
            expected_len_next = '0;
            member_len_next   = '0;
            written_cnt_next  = '0;
            error_next        = ST_OK;
            crc_ctl.init      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            byte_index_reg   <= '0;
            dict_size_reg    <= '0;
            stored_crc_reg   <= '0;
            expected_len_reg <= '0;
            member_len_reg   <= '0;
            written_cnt_reg  <= '0;
            error_reg        <= ST_OK;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            dict_size_reg    <= dict_size_next;
            stored_crc_reg   <= stored_crc_next;
            expected_len_reg <= expected_len_next;
            member_len_reg   <= member_len_next;
            written_cnt_reg  <= written_cnt_next;
            error_reg        <= error_next;
            if (req.ready)
            begin
                rsp_valid_reg <= req.valid;
            end
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            status_reg    <= status_next;
            rsp_dict_reg  <= rsp_dict_next;
            member_ok_reg <= member_ok_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.dict_size = rsp_dict_reg;
    assign rsp.member_ok = member_ok_reg;

`ifndef SYNTHESIS
    a_ok_means_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.member_ok |-> rsp.status == ST_OK)
        else $error("member_ok with nonzero status");

    a_finish_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && cmd == CMD_FINISH |=>
            phase_reg == PH_HEADER && byte_index_reg == '0 && error_reg == ST_OK)
        else $error("finish did not return to header phase");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER && byte_index_reg <= HEADER_LAST) ||
        (phase_reg == PH_TRAILER && byte_index_reg <= TRAILER_LAST) ||
        (phase_reg == PH_DATA && byte_index_reg == '0))
        else $error("byte index out of range for phase");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        written_cnt_reg <= expected_len_reg)
        else $error("output count passed expected size");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg != ST_OK && !(req_fire && cmd == CMD_FINISH) |=> $stable(error_reg))
        else $error("error code replaced before finish");

    a_rsp_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp_valid_reg)
        else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire
